/* rtl/pmpt_pkg.sv */
package pmpt_pkg;

	localparam int unsigned PosW      = 11;
	localparam int unsigned DeltaW    = 9;
	localparam int unsigned CfgIndexW = 8;

	localparam logic [PosW-1:0] XLimitReset  = PosW'(800);
	localparam logic [PosW-1:0] YLimitReset  = PosW'(600);
	localparam logic [PosW-1:0] PointerReset = PosW'(5);

	// head byte bit positions
	localparam int unsigned BitLeft   = 0;
	localparam int unsigned BitRight  = 1;
	localparam int unsigned BitMiddle = 2;
	localparam int unsigned BitSync   = 3;
	localparam int unsigned BitXSign  = 4;
	localparam int unsigned BitYSign  = 5;
	localparam int unsigned BitXOvf   = 6;
	localparam int unsigned BitYOvf   = 7;

	typedef enum logic [CfgIndexW-1:0] {
		REG_X_LIMIT = CfgIndexW'(0),
		REG_Y_LIMIT = CfgIndexW'(1)
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_HEAD,
		ST_DX,
		ST_DY
	} frame_state_t;

	typedef struct packed {
		logic [7:0] head;
		logic [7:0] dx_byte;
		logic [7:0] dy_byte;
	} packet_t;

	// framer <-> tracker handoff
	typedef struct packed {
		logic    valid;
		packet_t pkt;
	} packet_chan_t;

	typedef struct packed {
		logic [PosW-1:0] x_limit;
		logic [PosW-1:0] y_limit;
	} limits_t;

endpackage

/* rtl/pmpt_ifs.sv */
interface pmpt_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface pmpt_result_if;
	logic                             valid;
	logic                             ready;
	logic [pmpt_pkg::PosW-1:0]        x_pos;
	logic [pmpt_pkg::PosW-1:0]        y_pos;
	logic                             left_button;
	logic                             middle_button;
	logic                             right_button;
	logic signed [pmpt_pkg::DeltaW-1:0] move_x;
	logic signed [pmpt_pkg::DeltaW-1:0] move_y;
	logic                             x_overflow;
	logic                             y_overflow;
	modport source (output valid, output x_pos, output y_pos, output left_button,
		output middle_button, output right_button, output move_x, output move_y,
		output x_overflow, output y_overflow, input ready);
	modport sink (input valid, input x_pos, input y_pos, input left_button,
		input middle_button, input right_button, input move_x, input move_y,
		input x_overflow, input y_overflow, output ready);
endinterface

interface pmpt_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [pmpt_pkg::CfgIndexW-1:0]   index;
	logic [pmpt_pkg::PosW-1:0]        data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/pmpt_framer.sv */
module pmpt_framer (
	input  logic                  clk,
	input  logic                  arst_n,
	pmpt_byte_if.sink             rx,
	input  logic                  pkt_ready,
	output pmpt_pkg::packet_chan_t pkt_chan
);

	pmpt_pkg::frame_state_t state_q, state_d;
	logic [7:0]             head_q;
	logic [7:0]             dx_q;
	logic                   pkt_valid_s1;
	pmpt_pkg::packet_t      pkt_s1;
	logic                   accept;
	logic                   take_head;
	logic                   take_dx;
	logic                   take_dy;

	assign rx.ready = !pkt_valid_s1 || pkt_ready;
	assign accept   = rx.valid && rx.ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pmpt_pkg::ST_HEAD: if (accept && rx.rx_byte[pmpt_pkg::BitSync]) begin
				state_d = pmpt_pkg::ST_DX;
			end
			pmpt_pkg::ST_DX: if (accept) begin
				state_d = pmpt_pkg::ST_DY;
			end
			pmpt_pkg::ST_DY: if (accept) begin
				state_d = pmpt_pkg::ST_HEAD;
			end
			default: state_d = pmpt_pkg::ST_HEAD;
		endcase
	end

	always_comb begin
		take_head = 1'b0;
		take_dx   = 1'b0;
		take_dy   = 1'b0;
		unique case (state_q)
			pmpt_pkg::ST_HEAD: take_head = accept && rx.rx_byte[pmpt_pkg::BitSync];
			pmpt_pkg::ST_DX:   take_dx   = accept;
			pmpt_pkg::ST_DY:   take_dy   = accept;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= pmpt_pkg::ST_HEAD;
			pkt_valid_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			if (take_dy) begin
				pkt_valid_s1 <= 1'b1;
			end else if (pkt_ready) begin
				pkt_valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_head) begin
			head_q <= rx.rx_byte;
		end
		if (take_dx) begin
			dx_q <= rx.rx_byte;
		end
		if (take_dy) begin
			pkt_s1 <= '{head: head_q, dx_byte: dx_q, dy_byte: rx.rx_byte};
		end
	end

	assign pkt_chan = '{valid: pkt_valid_s1, pkt: pkt_s1};

`ifndef SYNTHESIS
	// a head byte without sync is dropped
	a_no_sync_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pmpt_pkg::ST_HEAD && accept && !rx.rx_byte[pmpt_pkg::BitSync])
		|=> (state_q == pmpt_pkg::ST_HEAD && !pkt_valid_s1))
		else $error("byte without sync bit started a packet");
	// a stalled packet holds
	a_pkt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(pkt_valid_s1 && !pkt_ready) |=> (pkt_valid_s1 && $stable(pkt_s1)))
		else $error("stalled packet lost or changed");
`endif

endmodule

/* rtl/pmpt_tracker.sv */
module pmpt_tracker (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pmpt_pkg::packet_chan_t pkt_chan,
	output logic                   pkt_ready,
	input  pmpt_pkg::limits_t      limits,
	pmpt_result_if.source          tx
);

	localparam int unsigned SumW = pmpt_pkg::PosW + 2;

	logic [pmpt_pkg::PosW-1:0]          pointer_x_q;
	logic [pmpt_pkg::PosW-1:0]          pointer_y_q;
	logic                               out_valid_q;
	logic                               pkt_take;
	logic [7:0]                         head;
	logic signed [pmpt_pkg::DeltaW-1:0] dx;
	logic signed [pmpt_pkg::DeltaW-1:0] dy;
	logic signed [SumW-1:0]             sum_x;
	logic signed [SumW-1:0]             sum_y;
	logic [pmpt_pkg::PosW-1:0]          next_x;
	logic [pmpt_pkg::PosW-1:0]          next_y;
	logic                               xov;
	logic                               yov;

	assign pkt_ready = !out_valid_q || tx.ready;
	assign pkt_take  = pkt_chan.valid && pkt_ready;

	assign head = pkt_chan.pkt.head;
	assign dx   = {head[pmpt_pkg::BitXSign], pkt_chan.pkt.dx_byte};
	assign dy   = {head[pmpt_pkg::BitYSign], pkt_chan.pkt.dy_byte};
	assign xov  = head[pmpt_pkg::BitXOvf];
	assign yov  = head[pmpt_pkg::BitYOvf];

	assign sum_x = $signed({2'b00, pointer_x_q}) + SumW'(dx);
	assign sum_y = $signed({2'b00, pointer_y_q}) - SumW'(dy);

	// clamp to 0..limit; overflowed axis keeps its place
	always_comb begin
		next_x = pointer_x_q;
		if (!xov) begin
			if (sum_x < 0) begin
				next_x = '0;
			end else if (sum_x > $signed({2'b00, limits.x_limit})) begin
				next_x = limits.x_limit;
			end else begin
				next_x = sum_x[pmpt_pkg::PosW-1:0];
			end
		end
	end

	always_comb begin
		next_y = pointer_y_q;
		if (!yov) begin
			if (sum_y < 0) begin
				next_y = '0;
			end else if (sum_y > $signed({2'b00, limits.y_limit})) begin
				next_y = limits.y_limit;
			end else begin
				next_y = sum_y[pmpt_pkg::PosW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pointer_x_q <= pmpt_pkg::PointerReset;
			pointer_y_q <= pmpt_pkg::PointerReset;
			out_valid_q <= 1'b0;
		end else begin
			if (pkt_take) begin
				pointer_x_q <= next_x;
				pointer_y_q <= next_y;
				out_valid_q <= 1'b1;
			end else if (tx.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pkt_take) begin
			tx.x_pos         <= next_x;
			tx.y_pos         <= next_y;
			tx.left_button   <= head[pmpt_pkg::BitLeft];
			tx.middle_button <= head[pmpt_pkg::BitMiddle];
			tx.right_button  <= head[pmpt_pkg::BitRight];
			tx.move_x        <= dx;
			tx.move_y        <= dy;
			tx.x_overflow    <= xov;
			tx.y_overflow    <= yov;
		end
	end

	assign tx.valid = out_valid_q;

`ifndef SYNTHESIS
	a_xov_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(pkt_take && xov) |=> $stable(pointer_x_q))
		else $error("x moved despite overflow");
	a_x_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(pkt_take && !xov) |=> (pointer_x_q <= $past(limits.x_limit)))
		else $error("x beyond limit after move");
	a_pos_matches: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_take |=> (out_valid_q && tx.x_pos == pointer_x_q && tx.y_pos == pointer_y_q))
		else $error("result position differs from pointer");
`endif

endmodule

/* rtl/ps2_mouse_packet_tracker_top.sv */
// PS/2 mouse packet tracker. Feed raw mouse bytes on rx, one per transaction;
// a packet opens only on a byte with the sync bit (bit 3) set, other bytes at
// packet start are dropped. Every third byte of a packet yields one result
// transaction on tx with the buttons, overflow flags, 9-bit signed moves and
// the pointer position (x += move_x, y -= move_y, each clamped to 0..limit;
// an overflowed axis stays put). Pointer starts at (5,5); limits reset to
// 800 and 600 and are written through cfg (index 0 x_limit, 1 y_limit, other
// indexes ignored); the user is to write them only while the block is idle,
// which the block does not enforce. Rate: one byte per clock, sustained while
// tx is ready; results pass the packet register, then the result register.
module ps2_mouse_packet_tracker_top (
	input  logic          clk,
	input  logic          arst_n,
	pmpt_byte_if.sink     rx,
	pmpt_result_if.source tx,
	pmpt_cfg_if.sink      cfg
);

	// clamp bounds; the user writes them only between packets, not enforced here
	pmpt_pkg::limits_t      limits_q;
	// assembled packet handed from framer to tracker
	pmpt_pkg::packet_chan_t pkt_chan;
	logic                   pkt_ready;

	// configuration never stalls
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.x_limit <= pmpt_pkg::XLimitReset;
			limits_q.y_limit <= pmpt_pkg::YLimitReset;
		end else if (cfg.valid) begin
			case (cfg.index)
				pmpt_pkg::REG_X_LIMIT: limits_q.x_limit <= cfg.data;
				pmpt_pkg::REG_Y_LIMIT: limits_q.y_limit <= cfg.data;
				default: ;
			endcase
		end
	end

	// byte framing: sync search, head and x byte holding
	pmpt_framer u_framer (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.pkt_ready(pkt_ready),
		.pkt_chan (pkt_chan)
	);

	// pointer update and result register
	pmpt_tracker u_tracker (
		.clk      (clk),
		.arst_n   (arst_n),
		.pkt_chan (pkt_chan),
		.pkt_ready(pkt_ready),
		.limits   (limits_q),
		.tx       (tx)
	);

endmodule
